// File: src/priority_task_scheduler_unit_macros.svh
// Assertion macros for the task scheduler checker.
// Both expect a signal named clk in the scope of use; PTSU_ASSERT also needs rst.
`ifndef PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ptsu_pkg.sv
package ptsu_pkg;

  localparam int unsigned KIND_W     = 3;
  localparam int unsigned PRI_W      = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned DEPTH_W    = 8;
  // Slot index carried between cells; covers up to 64 slots.
  localparam int unsigned IDX_W      = 6;

  localparam logic [PRI_W-1:0]   IDLE_PRIORITY = 8'd100;
  // Scan seed: one above any stored priority.
  localparam logic [PRI_W:0]     SCAN_SEED_PRI = 9'd256;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX     = 8'd255;

  localparam logic [KIND_W-1:0] KIND_CREATE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RUN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ENTER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXIT   = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_FULL         = 3'd1,
    ST_BAD_PRIORITY = 3'd2,
    ST_UNDERFLOW    = 3'd3,
    ST_IGNORED      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ctrl_state_t;

  // Running best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic             sweep;
    logic [PRI_W:0]   pri;
    logic [IDX_W-1:0] slot;
  } cand_t;

  // Slot table write broadcast to every cell.
  typedef struct packed {
    logic             create;
    logic             unready;
    logic [IDX_W-1:0] slot;
    logic [PRI_W-1:0] pri;
  } slot_cmd_t;

endpackage

// File: src/ptsu_req_if.sv
interface ptsu_req_if;
  import ptsu_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PRI_W-1:0]  task_priority;
  logic [TICK_W-1:0] delay_ticks;

  modport source (output valid, output kind, output task_priority, output delay_ticks,
                  input ready);
  modport sink (input valid, input kind, input task_priority, input delay_ticks,
                output ready);
endinterface

// File: src/ptsu_rsp_if.sv
interface ptsu_rsp_if;
  import ptsu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_OUT_W-1:0] new_slot;
  logic [SLOT_OUT_W-1:0] current_slot;
  logic                  switched;
  logic                  save_context;
  logic [TOTAL_W-1:0]    switch_total;
  logic [DEPTH_W-1:0]    interrupt_depth;

  modport source (output valid, output status, output new_slot, output current_slot,
                  output switched, output save_context, output switch_total,
                  output interrupt_depth, input ready);
  modport sink (input valid, input status, input new_slot, input current_slot,
                input switched, input save_context, input switch_total,
                input interrupt_depth, output ready);
endinterface

// File: src/ptsu_cell.sv
module ptsu_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  ptsu_pkg::slot_cmd_t cmd,
  input  ptsu_pkg::cand_t     cand_in,
  output ptsu_pkg::cand_t     cand_out
);
  import ptsu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic             used;
  logic             ready;
  logic [PRI_W-1:0] pri;
  logic             hit;
  logic             take;

  assign hit  = (cmd.slot == MY_IDX);
  // Equal priority: the later (higher) slot wins.
  assign take = used && ready && ({1'b0, pri} <= cand_in.pri);

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= (CELL_INDEX == 0);
      ready <= (CELL_INDEX == 0);
      pri   <= IDLE_PRIORITY;
    end else begin
      if (cmd.create && hit) begin
        used  <= 1'b1;
        ready <= 1'b1;
        pri   <= cmd.pri;
      end
      if (cmd.unready && hit) begin
        ready <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.sweep <= 1'b0;
    end else begin
      cand_out.sweep <= cand_in.sweep;
    end
    if (take) begin
      cand_out.pri  <= {1'b0, pri};
      cand_out.slot <= MY_IDX;
    end else begin
      cand_out.pri  <= cand_in.pri;
      cand_out.slot <= cand_in.slot;
    end
  end

endmodule

// File: src/priority_task_scheduler_unit.sv
// Events that need no rescheduling go from acceptance straight to the result
// register; events that reschedule first run the best-candidate sweep, which
// moves one slot cell per cycle. A new event is accepted only after the result
// of the last one has been loaded into the output register.
// Reset (synchronous, active high): slot 0 holds the idle task at priority 100,
// idle runs, counters and depth are cleared and the result register is emptied.
module priority_task_scheduler_unit #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input logic     clk,
  input logic     rst,
  ptsu_req_if.sink   req,
  ptsu_rsp_if.source rsp
);
  import ptsu_pkg::*;

  localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TASK_SLOTS + 1);

  // Control state.
  ctrl_state_t        state;
  ctrl_state_t        state_next;
  logic               go;
  logic [CNT_W-1:0]   next_free;
  logic [SLOT_W-1:0]  running;
  logic               started;
  logic [DEPTH_W-1:0] depth;
  logic [TOTAL_W-1:0] counter;
  logic               out_valid;

  // Event held between acceptance and the result.
  status_t            pend_status;
  logic [SLOT_W-1:0]  pend_new;
  logic               pend_delay;
  logic               pend_sw;

  // Output register.
  status_t               out_status;
  logic [SLOT_OUT_W-1:0] out_new;
  logic [SLOT_OUT_W-1:0] out_cur;
  logic                  out_sw;
  logic                  out_save;
  logic [TOTAL_W-1:0]    out_total;
  logic [DEPTH_W-1:0]    out_depth;

  // Decode of the accepted event.
  logic               acc;
  logic               load;
  logic               scan_done;
  logic [SLOT_W-1:0]  best;
  status_t            dec_status;
  logic               dec_sched;
  logic               dec_create;
  logic               dec_unready;
  logic               dec_start;
  logic [DEPTH_W-1:0] dec_depth;
  slot_cmd_t          cmd;

  cand_t cand [0:TASK_SLOTS];

  // ---------------------------------------------------------------------------
  // Slot table: one cell per task slot. A scan enters at cell 0 with a
  // priority worse than any task and leaves the last cell holding the winner.
  // ---------------------------------------------------------------------------
  assign cand[0] = '{sweep: go, pri: SCAN_SEED_PRI, slot: '0};

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    ptsu_cell #(.CELL_INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .cand_in  (cand[i]),
      .cand_out (cand[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Sequencer next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = dec_sched ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs and event decode
  // ---------------------------------------------------------------------------
  always_comb begin
    acc       = req.valid && (state == S_IDLE);
    load      = (state == S_DONE) && (!out_valid || rsp.ready);
    scan_done = (state == S_SCAN) && cand[TASK_SLOTS].sweep;
    best      = cand[TASK_SLOTS].slot[SLOT_W-1:0];

    dec_status  = ST_OK;
    dec_sched   = 1'b0;
    dec_create  = 1'b0;
    dec_unready = 1'b0;
    dec_start   = 1'b0;
    dec_depth   = depth;
    case (req.kind)
      KIND_CREATE: begin
        // Bad priority is checked before a full table.
        if (req.task_priority >= IDLE_PRIORITY) begin
          dec_status = ST_BAD_PRIORITY;
        end else if (next_free == CNT_W'(TASK_SLOTS)) begin
          dec_status = ST_FULL;
        end else begin
          dec_create = 1'b1;
          dec_sched  = started;
        end
      end
      KIND_RUN: begin
        dec_start = 1'b1;
        dec_sched = 1'b1;
      end
      KIND_DELAY: begin
        // The idle task is never delayed, so some task always stays ready.
        if ((req.delay_ticks == '0) || (running == '0)) begin
          dec_status = ST_IGNORED;
        end else begin
          dec_unready = 1'b1;
          dec_sched   = 1'b1;
        end
      end
      KIND_ENTER: begin
        if (depth != DEPTH_MAX) begin
          dec_depth = depth + 8'd1;
        end
      end
      KIND_EXIT: begin
        if (depth == '0) begin
          dec_status = ST_UNDERFLOW;
        end else begin
          dec_depth = depth - 8'd1;
          dec_sched = (depth == 8'd1);
        end
      end
      default: dec_status = ST_IGNORED;
    endcase

    cmd.create  = acc && dec_create;
    cmd.unready = acc && dec_unready;
    cmd.slot    = dec_create ? IDX_W'(next_free[SLOT_W-1:0]) : IDX_W'(running);
    cmd.pri     = req.task_priority;

    req.ready = (state == S_IDLE);
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      go        <= 1'b0;
      next_free <= CNT_W'(1);
      running   <= '0;
      started   <= 1'b0;
      depth     <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Launch the scan in the next cycle so the cells already hold this event.
      go    <= acc && dec_sched;
      if (acc) begin
        depth <= dec_depth;
        if (dec_start) begin
          started <= 1'b1;
        end
        if (dec_create) begin
          next_free <= next_free + CNT_W'(1);
        end
      end
      if (scan_done && (best != running)) begin
        running <= best;
        counter <= counter + 32'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pending event and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status <= dec_status;
      pend_new    <= dec_create ? next_free[SLOT_W-1:0] : '0;
      pend_delay  <= (req.kind == KIND_DELAY);
      pend_sw     <= 1'b0;
    end
    if (scan_done) begin
      pend_sw <= (best != running);
    end
    if (load) begin
      out_status <= pend_status;
      out_new    <= SLOT_OUT_W'(pend_new);
      out_cur    <= SLOT_OUT_W'(running);
      out_sw     <= pend_sw;
      // Old context is saved only when a delay hands the processor away.
      out_save   <= pend_delay && pend_sw;
      out_total  <= counter;
      out_depth  <= depth;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.new_slot        = out_new;
  assign rsp.current_slot    = out_cur;
  assign rsp.switched        = out_sw;
  assign rsp.save_context    = out_save;
  assign rsp.switch_total    = out_total;
  assign rsp.interrupt_depth = out_depth;

endmodule

// File: src/ptsu_checker.sv
`include "priority_task_scheduler_unit_macros.svh"

module ptsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_switch_total
);

  // One event in flight: after a transaction, hold off the next one.
  `PTSU_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "second event accepted while busy")

  // A result never shows up in the cycle right after its event.
  `PTSU_ASSERT(a_min_latency, req_valid && req_ready |=> !$rose(rsp_valid), "result too early")

  // A stalled result holds.
  `PTSU_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_switch_total), "stalled result changed")

  // Reset drops any pending result.
  `PTSU_ASSERT_ALWAYS(a_reset_clears, rst |=> !rsp_valid, "result valid after reset")

endmodule

bind priority_task_scheduler_unit ptsu_checker u_ptsu_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_switch_total (rsp.switch_total)
);
